FILE: src/tfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, widths and constants of the tilt and flex-sensor conditioning
// block.
// ----------------------------------------------------------------------------
package tfc_pkg;

  // Field widths.
  localparam int ACCEL_W   = 16;
  localparam int ADC_W     = 10;
  localparam int PITCH_W   = 8;
  localparam int PERCENT_W = 7;

  // Configuration port.
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THROTTLE_LOW        = 2'd0,
    CFG_THROTTLE_HIGH       = 2'd1,
    CFG_DIRECTION_THRESHOLD = 2'd2
  } cfg_reg_e;

  localparam logic [ADC_W-1:0] THROTTLE_LOW_RST        = 10'd750;
  localparam logic [ADC_W-1:0] THROTTLE_HIGH_RST       = 10'd1023;
  localparam logic [ADC_W-1:0] DIRECTION_THRESHOLD_RST = 10'd800;

  // Pitch path.
  localparam int SQ_W        = 2 * ACCEL_W - 1;   // one squared axis
  localparam int SUM_W       = 2 * ACCEL_W;       // y*y + z*z
  localparam int ROOT_W      = SUM_W;             // sqrt of sum with 16 fraction bits
  localparam int SQRT_STEPS  = ROOT_W;            // one root bit per stage
  localparam int REM_W       = ROOT_W + 3;
  localparam int OPP_W       = ACCEL_W + 1;       // -x without overflow
  localparam int FRAC_BITS   = 16;
  localparam int XY_W        = ROOT_W + 4;
  localparam int Z_W         = 25;
  localparam int ATAN_W      = 23;
  localparam int CORDIC_STEPS = 20;
  localparam int ANGLE_GUARD = 64;
  localparam int PITCH_LIMIT = 90;
  localparam int DEG_W       = Z_W - FRAC_BITS;

  // atan(2^-i) in degrees with 16 fraction bits, rounded.
  localparam logic [ATAN_W-1:0] ATAN_DEG [32] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
    23'd234379,  23'd117304,  23'd58666,  23'd29335,
    23'd14668,   23'd7334,    23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,
    23'd57,      23'd29,      23'd14,     23'd7,
    23'd4,       23'd2,       23'd1,      23'd0,
    23'd0,       23'd0,       23'd0,      23'd0,
    23'd0,       23'd0,       23'd0,      23'd0
  };

  // Throttle path.
  localparam int THROTTLE_SPAN = 100;
  localparam int NUM_W         = 17;              // 1023 * 100 fits
  localparam int QUO_W         = PERCENT_W;       // quotient never exceeds 100
  localparam int FLEX_LAT      = 1 + QUO_W;

  // Register stages ahead of the output register on each path.
  localparam int PITCH_LAT = 2 + SQRT_STEPS + CORDIC_STEPS;
  localparam int FLEX_DLY  = PITCH_LAT - FLEX_LAT;

  // Sideband that travels with the pitch operands.
  typedef struct packed {
    logic [OPP_W-1:0] opp;   // -x, two's complement
    logic             zero;  // y and z both zero
  } side_t;

  // One stage of the throttle divider.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [ADC_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             en;
    logic             dir;
  } div_t;

  // Throttle and direction results on their way to the output register.
  typedef struct packed {
    logic [PERCENT_W-1:0] percent;
    logic                 forward;
  } flex_t;

endpackage

FILE: src/tfc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_sqrt
// Pipelined floor square root of (sum << 32), one root bit per stage.
// ----------------------------------------------------------------------------
module tfc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [tfc_pkg::SUM_W-1:0]   sum_i,
  input  tfc_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [tfc_pkg::ROOT_W-1:0]  root_o,
  output tfc_pkg::side_t              side_o
);

  localparam int N = tfc_pkg::SQRT_STEPS;

  logic [N-1:0]                valid_q;
  logic [tfc_pkg::SUM_W-1:0]   rad_q  [N];
  logic [tfc_pkg::REM_W-1:0]   rem_q  [N];
  logic [tfc_pkg::ROOT_W-1:0]  root_q [N];
  tfc_pkg::side_t              side_q [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                        valid_in;
    logic [tfc_pkg::SUM_W-1:0]   rad_in;
    logic [tfc_pkg::REM_W-1:0]   rem_in;
    logic [tfc_pkg::ROOT_W-1:0]  root_in;
    tfc_pkg::side_t              side_in;
    logic [tfc_pkg::REM_W-1:0]   rem_sh;
    logic [tfc_pkg::REM_W-1:0]   trial;
    logic                        take;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign rad_in   = sum_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign rad_in   = rad_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign root_in  = root_q[s-1];
      assign side_in  = side_q[s-1];
    end

    // The radicand's two next bits come off the top of the shifting sum; the
    // low 32 bits of the radicand are zero and shift in behind it.
    assign rem_sh = {rem_in[tfc_pkg::REM_W-3:0], rad_in[tfc_pkg::SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_in << 2;
      rem_q[s]  <= take ? rem_sh - trial : rem_sh;
      root_q[s] <= {root_in[tfc_pkg::ROOT_W-2:0], take};
      side_q[s] <= side_in;
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

FILE: src/tfc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_cordic
// Pipelined vectoring CORDIC: rotates (root, -x) onto the x axis and
// accumulates the angle in degrees with 16 fraction bits.
// ----------------------------------------------------------------------------
module tfc_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [tfc_pkg::ROOT_W-1:0]        root_i,
  input  tfc_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [tfc_pkg::Z_W-1:0]    angle_o,
  output tfc_pkg::side_t                    side_o
);

  localparam int N = tfc_pkg::CORDIC_STEPS;

  logic [N-1:0]                   valid_q;
  logic signed [tfc_pkg::XY_W-1:0] x_q [N];
  logic signed [tfc_pkg::XY_W-1:0] y_q [N];
  logic signed [tfc_pkg::Z_W-1:0]  z_q [N];
  tfc_pkg::side_t                  side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                            valid_in;
    logic signed [tfc_pkg::XY_W-1:0] x_in;
    logic signed [tfc_pkg::XY_W-1:0] y_in;
    logic signed [tfc_pkg::Z_W-1:0]  z_in;
    tfc_pkg::side_t                  side_in;
    logic signed [tfc_pkg::XY_W-1:0] dx;
    logic signed [tfc_pkg::XY_W-1:0] dy;
    logic signed [tfc_pkg::Z_W-1:0]  dz;

    if (i == 0) begin : g_first
      assign valid_in = valid_i;
      assign x_in     = $signed({{(tfc_pkg::XY_W - tfc_pkg::ROOT_W){1'b0}}, root_i});
      assign y_in     = $signed({{(tfc_pkg::XY_W - tfc_pkg::OPP_W - tfc_pkg::FRAC_BITS)
                                   {side_i.opp[tfc_pkg::OPP_W-1]}},
                                 side_i.opp, {tfc_pkg::FRAC_BITS{1'b0}}});
      assign z_in     = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[i-1];
      assign x_in     = x_q[i-1];
      assign y_in     = y_q[i-1];
      assign z_in     = z_q[i-1];
      assign side_in  = side_q[i-1];
    end

    // Arithmetic shifts round toward minus infinity, as the angle math expects.
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign dz = $signed({{(tfc_pkg::Z_W - tfc_pkg::ATAN_W){1'b0}}, tfc_pkg::ATAN_DEG[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!y_in[tfc_pkg::XY_W-1]) begin
        x_q[i] <= x_in + dx;
        y_q[i] <= y_in - dy;
        z_q[i] <= z_in + dz;
      end else begin
        x_q[i] <= x_in - dx;
        y_q[i] <= y_in + dy;
        z_q[i] <= z_in - dz;
      end
      side_q[i] <= side_in;
    end
  end

  assign valid_o = valid_q[N-1];
  assign angle_o = z_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

FILE: src/tfc_flex.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_flex
// Throttle clamp, linear map to percent by a pipelined restoring divider, and
// the direction threshold compare.
// ----------------------------------------------------------------------------
module tfc_flex (
  input  logic                          clk_i,
  input  logic [tfc_pkg::ADC_W-1:0]     throttle_sample_i,
  input  logic [tfc_pkg::ADC_W-1:0]     direction_sample_i,
  input  logic [tfc_pkg::ADC_W-1:0]     throttle_low_i,
  input  logic [tfc_pkg::ADC_W-1:0]     throttle_high_i,
  input  logic [tfc_pkg::ADC_W-1:0]     direction_threshold_i,
  output tfc_pkg::flex_t                flex_o
);

  localparam int N = tfc_pkg::QUO_W;

  logic [tfc_pkg::ADC_W-1:0] t_hi;
  logic [tfc_pkg::ADC_W-1:0] t_clamp;
  logic [tfc_pkg::ADC_W-1:0] t_diff;
  tfc_pkg::div_t             prep_d;
  tfc_pkg::div_t             prep_q;
  tfc_pkg::div_t             div_q [N];

  // Upper bound first, then lower bound, so a reversed window settles on low.
  always_comb begin
    t_hi    = (throttle_sample_i > throttle_high_i) ? throttle_high_i : throttle_sample_i;
    t_clamp = (t_hi < throttle_low_i) ? throttle_low_i : t_hi;
    t_diff  = t_clamp - throttle_low_i;
    prep_d.rem = tfc_pkg::NUM_W'(t_diff) * tfc_pkg::NUM_W'(tfc_pkg::THROTTLE_SPAN);
    prep_d.den = throttle_high_i - throttle_low_i;
    prep_d.quo = '0;
    prep_d.en  = (throttle_high_i > throttle_low_i);
    prep_d.dir = (direction_sample_i < direction_threshold_i);
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  // The numerator never exceeds 100 times the divisor, so seven quotient bits
  // cover it.
  for (genvar j = 0; j < N; j++) begin : g_div
    localparam int K = N - 1 - j;
    tfc_pkg::div_t              cur;
    tfc_pkg::div_t              nxt;
    logic [tfc_pkg::NUM_W-1:0]  dsh;

    if (j == 0) begin : g_first
      assign cur = prep_q;
    end else begin : g_next
      assign cur = div_q[j-1];
    end

    always_comb begin
      dsh = tfc_pkg::NUM_W'(cur.den) << K;
      nxt = cur;
      if (cur.rem >= dsh) begin
        nxt.rem = cur.rem - dsh;
        nxt.quo = cur.quo | (tfc_pkg::QUO_W'(1) << K);
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[j] <= nxt;
    end
  end

  always_comb begin
    flex_o.percent = div_q[N-1].en
                   ? tfc_pkg::PERCENT_W'(tfc_pkg::THROTTLE_SPAN) - div_q[N-1].quo
                   : tfc_pkg::PERCENT_W'(tfc_pkg::THROTTLE_SPAN);
    flex_o.forward = div_q[N-1].dir;
  end

endmodule

FILE: src/tilt_and_flex_sensor_conditioning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_and_flex_sensor_conditioning
// Pitch from an accelerometer triple by square root and CORDIC, throttle
// percent from a clamped linear map, and a direction flag from a threshold.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -----------------------------------------
//  input     start, busy               accel_x/y/z_i, throttle_sample_i,
//                                      direction_sample_i
//  result    result_valid_o (strobe)   pitch_degrees_o, throttle_percent_o,
//                                      direction_forward_o
//  config    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A transaction is taken in every cycle; busy stays low. Each result passes
// through stage A, stage B, the 32 square-root stages, the CORDIC stages and
// the output register. Results are strobed for one cycle each, in order, and
// the receiver cannot stall. Reset clears the valid bits and loads the
// register reset values.
// ----------------------------------------------------------------------------
module tilt_and_flex_sensor_conditioning (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  cfg_we_i,
  input  logic [tfc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [tfc_pkg::ADC_W-1:0]             cfg_wdata_i,
  input  logic signed [tfc_pkg::ACCEL_W-1:0]    accel_x_i,
  input  logic signed [tfc_pkg::ACCEL_W-1:0]    accel_y_i,
  input  logic signed [tfc_pkg::ACCEL_W-1:0]    accel_z_i,
  input  logic [tfc_pkg::ADC_W-1:0]             throttle_sample_i,
  input  logic [tfc_pkg::ADC_W-1:0]             direction_sample_i,
  output logic                                  result_valid_o,
  output logic signed [tfc_pkg::PITCH_W-1:0]    pitch_degrees_o,
  output logic [tfc_pkg::PERCENT_W-1:0]         throttle_percent_o,
  output logic                                  direction_forward_o
);

  // Configuration registers.
  logic [tfc_pkg::ADC_W-1:0] thr_low_q;
  logic [tfc_pkg::ADC_W-1:0] thr_high_q;
  logic [tfc_pkg::ADC_W-1:0] dir_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_low_q  <= tfc_pkg::THROTTLE_LOW_RST;
      thr_high_q <= tfc_pkg::THROTTLE_HIGH_RST;
      dir_thr_q  <= tfc_pkg::DIRECTION_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (tfc_pkg::cfg_reg_e'(cfg_idx_i))
        tfc_pkg::CFG_THROTTLE_LOW:        thr_low_q  <= cfg_wdata_i;
        tfc_pkg::CFG_THROTTLE_HIGH:       thr_high_q <= cfg_wdata_i;
        tfc_pkg::CFG_DIRECTION_THRESHOLD: dir_thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage A: squares and the negated x axis.
  logic                                valid_a_q;
  logic signed [2*tfc_pkg::ACCEL_W-1:0] yy_full;
  logic signed [2*tfc_pkg::ACCEL_W-1:0] zz_full;
  logic [tfc_pkg::SQ_W-1:0]            yy_q;
  logic [tfc_pkg::SQ_W-1:0]            zz_q;
  logic [tfc_pkg::OPP_W-1:0]           opp_a_q;

  assign yy_full = tfc_pkg::SUM_W'(accel_y_i) * tfc_pkg::SUM_W'(accel_y_i);
  assign zz_full = tfc_pkg::SUM_W'(accel_z_i) * tfc_pkg::SUM_W'(accel_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    yy_q    <= yy_full[tfc_pkg::SQ_W-1:0];
    zz_q    <= zz_full[tfc_pkg::SQ_W-1:0];
    opp_a_q <= tfc_pkg::OPP_W'(0) - {accel_x_i[tfc_pkg::ACCEL_W-1], accel_x_i};
  end

  // Stage B: the exact sum of squares.
  logic                      valid_b_q;
  logic [tfc_pkg::SUM_W-1:0] sum_b_d;
  logic [tfc_pkg::SUM_W-1:0] sum_b_q;
  tfc_pkg::side_t            side_b_q;

  assign sum_b_d = tfc_pkg::SUM_W'(yy_q) + tfc_pkg::SUM_W'(zz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_b_q       <= sum_b_d;
    side_b_q.opp  <= opp_a_q;
    side_b_q.zero <= (sum_b_d == '0);
  end

  // Square root and CORDIC.
  logic                       sq_valid;
  logic [tfc_pkg::ROOT_W-1:0] sq_root;
  tfc_pkg::side_t             sq_side;

  tfc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_b_q),
    .sum_i   (sum_b_q),
    .side_i  (side_b_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  logic                           cd_valid;
  logic signed [tfc_pkg::Z_W-1:0] cd_angle;
  tfc_pkg::side_t                 cd_side;

  tfc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (cd_valid),
    .angle_o (cd_angle),
    .side_o  (cd_side)
  );

  // Throttle and direction, delayed to line up with the pitch.
  tfc_pkg::flex_t flex_res;
  tfc_pkg::flex_t flex_dly_q [tfc_pkg::FLEX_DLY];

  tfc_flex u_flex (
    .clk_i                 (clk_i),
    .throttle_sample_i     (throttle_sample_i),
    .direction_sample_i    (direction_sample_i),
    .throttle_low_i        (thr_low_q),
    .throttle_high_i       (thr_high_q),
    .direction_threshold_i (dir_thr_q),
    .flex_o                (flex_res)
  );

  for (genvar d = 0; d < tfc_pkg::FLEX_DLY; d++) begin : g_dly
    if (d == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        flex_dly_q[d] <= flex_res;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        flex_dly_q[d] <= flex_dly_q[d-1];
      end
    end
  end

  // Output stage: add a small guard to the angle magnitude and truncate it, saturate, and
  // handle the straight up or down case where y and z are both zero.
  logic [tfc_pkg::Z_W-1:0]     ang_mag;
  logic [tfc_pkg::Z_W-1:0]     ang_bias;
  logic [tfc_pkg::DEG_W-1:0]   deg_raw;
  logic [tfc_pkg::PITCH_W-1:0] deg_sat;
  logic [tfc_pkg::PITCH_W-1:0] pitch_d;
  logic                        opp_pos;
  logic                        opp_neg;

  always_comb begin
    ang_mag  = cd_angle[tfc_pkg::Z_W-1] ? tfc_pkg::Z_W'(-cd_angle) : tfc_pkg::Z_W'(cd_angle);
    ang_bias = ang_mag + tfc_pkg::Z_W'(tfc_pkg::ANGLE_GUARD);
    deg_raw  = ang_bias[tfc_pkg::Z_W-1:tfc_pkg::FRAC_BITS];
    deg_sat  = (deg_raw > tfc_pkg::DEG_W'(tfc_pkg::PITCH_LIMIT))
             ? tfc_pkg::PITCH_W'(tfc_pkg::PITCH_LIMIT)
             : tfc_pkg::PITCH_W'(deg_raw);
    opp_neg  = cd_side.opp[tfc_pkg::OPP_W-1];
    opp_pos  = !opp_neg && (cd_side.opp != '0);
    if (cd_side.zero) begin
      if (opp_pos) begin
        pitch_d = tfc_pkg::PITCH_W'(tfc_pkg::PITCH_LIMIT);
      end else if (opp_neg) begin
        pitch_d = tfc_pkg::PITCH_W'(0) - tfc_pkg::PITCH_W'(tfc_pkg::PITCH_LIMIT);
      end else begin
        pitch_d = '0;
      end
    end else if (cd_angle[tfc_pkg::Z_W-1]) begin
      pitch_d = tfc_pkg::PITCH_W'(0) - deg_sat;
    end else begin
      pitch_d = deg_sat;
    end
  end

  logic                          result_valid_q;
  logic [tfc_pkg::PITCH_W-1:0]   pitch_q;
  logic [tfc_pkg::PERCENT_W-1:0] percent_q;
  logic                          forward_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q   <= pitch_d;
    percent_q <= flex_dly_q[tfc_pkg::FLEX_DLY-1].percent;
    forward_q <= flex_dly_q[tfc_pkg::FLEX_DLY-1].forward;
  end

  assign result_valid_o      = result_valid_q;
  assign pitch_degrees_o     = $signed(pitch_q);
  assign throttle_percent_o  = percent_q;
  assign direction_forward_o = forward_q;

endmodule
